@@ rtl/ipnos_pkg.sv @@
// Shared types and constants of the in-path nearest object select block.
package ipnos_pkg;

    localparam int CoordW      = 24;
    localparam int TrigW       = 18;
    localparam int HalfW       = 23;
    localparam int DiffW       = CoordW + 1;
    localparam int ProdW       = TrigW + DiffW;
    localparam int SumW        = ProdW + 2;
    localparam int RotW        = SumW - 16;
    localparam int IndexW      = 8;
    localparam int CfgIndexW   = 4;
    localparam int CfgDataW    = 24;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int MaxObjectsDefault = 256;

    localparam logic [CfgIndexW-1:0] RegFrameCos    = 4'd0;
    localparam logic [CfgIndexW-1:0] RegFrameSin    = 4'd1;
    localparam logic [CfgIndexW-1:0] RegOriginX     = 4'd2;
    localparam logic [CfgIndexW-1:0] RegOriginY     = 4'd3;
    localparam logic [CfgIndexW-1:0] RegWindowLow   = 4'd4;
    localparam logic [CfgIndexW-1:0] RegWindowHigh  = 4'd5;
    localparam logic [CfgIndexW-1:0] RegLaneHalf    = 4'd6;
    localparam logic [CfgIndexW-1:0] RegLateralGate = 4'd7;

    typedef struct packed {
        logic signed [TrigW-1:0]  frame_cos;
        logic signed [TrigW-1:0]  frame_sin;
        logic signed [CoordW-1:0] frame_origin_x;
        logic signed [CoordW-1:0] frame_origin_y;
        logic signed [CoordW-1:0] window_low;
        logic signed [CoordW-1:0] window_high;
        logic [HalfW-1:0]         lane_half_width;
        logic                     lateral_gate_on;
    } cfg_t;

    // One classified object as it travels from front to back.
    typedef struct packed {
        logic                     pass;
        logic                     last;
        logic signed [CoordW-1:0] x_dist;
    } item_t;

endpackage

@@ rtl/ipnos_front.sv @@
// Front part: frame transform and gating of each object, three register stages.
module ipnos_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ipnos_pkg::cfg_t                   cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ipnos_pkg::CoordW-1:0] in_x,
    input  logic signed [ipnos_pkg::CoordW-1:0] in_y,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ipnos_pkg::item_t                  out_item
);
    import ipnos_pkg::*;

    logic                     en;
    logic                     v0_reg, v1_reg, v2_reg;
    logic signed [DiffW-1:0]  dx_reg, dy_reg;
    logic                     last0_reg, last1_reg;
    logic signed [ProdW-1:0]  pcx_reg, psy_reg, pcy_reg, psx_reg;
    item_t                    item_reg;
    item_t                    item_next;

    logic signed [TrigW-1:0]  c, s;
    logic signed [CoordW-1:0] ox, oy, wlo, whi;
    logic signed [DiffW-1:0]  dx_next, dy_next;
    logic signed [SumW-1:0]   sum_x, sum_y;
    logic signed [RotW-1:0]   xr, yr;
    logic [RotW-1:0]          ay;

    assign c   = cfg.frame_cos;
    assign s   = cfg.frame_sin;
    assign ox  = cfg.frame_origin_x;
    assign oy  = cfg.frame_origin_y;
    assign wlo = cfg.window_low;
    assign whi = cfg.window_high;

    // Advance the whole pipe unless the last stage holds an item it cannot hand off.
    assign en       = !v2_reg || out_ready;
    assign in_ready = en;

    assign dx_next = DiffW'(in_x) - DiffW'(ox);
    assign dy_next = DiffW'(in_y) - DiffW'(oy);

    // Round to nearest, ties up: add half an LSB, then drop 16 bits.
    assign sum_x = SumW'(pcx_reg) + SumW'(psy_reg) + SumW'(32768);
    assign sum_y = SumW'(pcy_reg) - SumW'(psx_reg) + SumW'(32768);
    assign xr    = sum_x[SumW-1:16];
    assign yr    = sum_y[SumW-1:16];
    assign ay    = yr[RotW-1] ? RotW'(-yr) : RotW'(yr);

    always_comb begin
        item_next.last   = last1_reg;
        item_next.x_dist = xr[CoordW-1:0];
        item_next.pass   = (xr > RotW'(wlo)) && (xr < RotW'(whi));
        if (cfg.lateral_gate_on && !(ay < RotW'(cfg.lane_half_width))) begin
            item_next.pass = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            last0_reg <= in_last;
            pcx_reg   <= c * dx_reg;
            psy_reg   <= s * dy_reg;
            pcy_reg   <= c * dy_reg;
            psx_reg   <= s * dx_reg;
            last1_reg <= last0_reg;
            item_reg  <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/ipnos_queue.sv @@
// Short queue of classified objects between front and back parts.
module ipnos_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ipnos_pkg::item_t  push_item,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output ipnos_pkg::item_t  pop_item
);
    import ipnos_pkg::*;

    item_t                store_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg;

    assign not_full  = count_reg != (QueuePtrW+1)'(QueueDepth);
    assign not_empty = count_reg != '0;
    assign pop_item  = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/ipnos_back.sv @@
// Back part: running minimum over the list and the result register.
module ipnos_back #(
    parameter int MAX_OBJECTS = ipnos_pkg::MaxObjectsDefault
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ipnos_pkg::item_t                    in_item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic                                res_found,
    output logic [ipnos_pkg::IndexW-1:0]        res_index,
    output logic signed [ipnos_pkg::CoordW-1:0] res_dist
);
    import ipnos_pkg::*;

    logic                     pop;
    logic [IndexW-1:0]        count_reg, count_next;
    logic                     full_reg, full_next;
    logic                     have_reg, have_next;
    logic [IndexW-1:0]        pos_reg, pos_next;
    logic signed [CoordW-1:0] best_reg, best_next;
    logic                     rv_reg, rv_next;
    logic                     rf_reg, rf_next;
    logic [IndexW-1:0]        ri_reg, ri_next;
    logic signed [CoordW-1:0] rd_reg, rd_next;

    assign in_ready = !rv_reg || res_ready;
    assign pop      = in_valid && in_ready;

    always_comb begin
        count_next = count_reg;
        full_next  = full_reg;
        have_next  = have_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        rv_next    = rv_reg && !res_ready;
        rf_next    = rf_reg;
        ri_next    = ri_reg;
        rd_next    = rd_reg;
        if (pop && !full_reg) begin
            if (in_item.pass && (!have_reg || in_item.x_dist < best_reg)) begin
                have_next = 1'b1;
                pos_next  = count_reg;
                best_next = in_item.x_dist;
            end
            if ({1'b0, count_reg} >= (IndexW+1)'(MAX_OBJECTS - 1)) begin
                full_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
        if (pop && in_item.last) begin
            rv_next    = 1'b1;
            rf_next    = have_next;
            ri_next    = have_next ? pos_next : '0;
            rd_next    = have_next ? best_next : '0;
            count_next = '0;
            full_next  = 1'b0;
            have_next  = 1'b0;
            pos_next   = '0;
            best_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            full_reg  <= 1'b0;
            have_reg  <= 1'b0;
            pos_reg   <= '0;
            best_reg  <= '0;
            rv_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            full_reg  <= full_next;
            have_reg  <= have_next;
            pos_reg   <= pos_next;
            best_reg  <= best_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge aclk) begin
        rf_reg <= rf_next;
        ri_reg <= ri_next;
        rd_reg <= rd_next;
    end

    assign res_valid = rv_reg;
    assign res_found = rf_reg;
    assign res_index = ri_reg;
    assign res_dist  = rd_reg;

endmodule

@@ rtl/in_path_nearest_object_select_top.sv @@
// Top level of the in-path nearest object select block.
// Path: an object enters the transform pipe at acceptance; the result of a list
// is registered after its last object has passed the 3 front stages, the queue and the
// result register, the first stage loading at the edge that accepts that object.
// Throughput: one object per cycle while neither a full queue nor a held result stalls,
// set by the pipelined transform and the running-minimum update in the back part.
// Reset: synchronous active-low aresetn clears all handshake, queue and list state and
// loads the register defaults; payload registers are not reset.
module in_path_nearest_object_select_top #(
    parameter int MAX_OBJECTS = ipnos_pkg::MaxObjectsDefault
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [ipnos_pkg::CfgIndexW-1:0]        cfg_index,
    input  logic [ipnos_pkg::CfgDataW-1:0]         cfg_data,
    // object input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ipnos_pkg::CoordW-1:0]    s_object_x,
    input  logic signed [ipnos_pkg::CoordW-1:0]    s_object_y,
    input  logic                                   s_last_object,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_found,
    output logic [ipnos_pkg::IndexW-1:0]           m_best_index,
    output logic signed [ipnos_pkg::CoordW-1:0]    m_best_distance
);
    import ipnos_pkg::*;

    cfg_t  cfg_reg;
    logic  front_valid;
    logic  queue_not_full;
    logic  queue_not_empty;
    logic  back_ready;
    item_t front_item;
    item_t queue_item;

    // Register file: take a write whenever the enable is high, drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_cos       <= TrigW'(65536);
            cfg_reg.frame_sin       <= '0;
            cfg_reg.frame_origin_x  <= '0;
            cfg_reg.frame_origin_y  <= '0;
            cfg_reg.window_low      <= '0;
            cfg_reg.window_high     <= CoordW'(255974);
            cfg_reg.lane_half_width <= HalfW'(448);
            cfg_reg.lateral_gate_on <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegFrameCos:    cfg_reg.frame_cos       <= cfg_data[TrigW-1:0];
                RegFrameSin:    cfg_reg.frame_sin       <= cfg_data[TrigW-1:0];
                RegOriginX:     cfg_reg.frame_origin_x  <= cfg_data[CoordW-1:0];
                RegOriginY:     cfg_reg.frame_origin_y  <= cfg_data[CoordW-1:0];
                RegWindowLow:   cfg_reg.window_low      <= cfg_data[CoordW-1:0];
                RegWindowHigh:  cfg_reg.window_high     <= cfg_data[CoordW-1:0];
                RegLaneHalf:    cfg_reg.lane_half_width <= cfg_data[HalfW-1:0];
                RegLateralGate: cfg_reg.lateral_gate_on <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front: transform each position into the frame and classify it against the gates.
    ipnos_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (s_object_x),
        .in_y      (s_object_y),
        .in_last   (s_last_object),
        .out_valid (front_valid),
        .out_ready (queue_not_full),
        .out_item  (front_item)
    );

    // Queue: decouple a stalled result channel from the transform pipe.
    ipnos_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid && queue_not_full),
        .push_item (front_item),
        .not_full  (queue_not_full),
        .pop       (queue_not_empty && back_ready),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    // Back: keep the first nearest passing object and report it at the end of a list.
    ipnos_back #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_not_empty),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_found (m_found),
        .res_index (m_best_index),
        .res_dist  (m_best_distance)
    );

    // A result without a found object carries zero index and distance.
    a_empty_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_best_index == '0 && m_best_distance == '0)
        else $error("empty result carries nonzero payload");

    // A reported index stays inside the list limit.
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> {1'b0, m_best_index} <= (IndexW+1)'(MAX_OBJECTS - 1))
        else $error("result index beyond list limit");

    // Input stalls only while the front's last stage is blocked by a full queue.
    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> front_valid && !queue_not_full)
        else $error("input stalled without back pressure");

    // No result right after reset.
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
